/* hdl/fwks_pkg.sv */
// Package for the keyed FIFO: operation and status codes, shared structs.
// No dependencies.
`default_nettype none
package fwks_pkg;
    typedef enum logic [1:0] {OP_PUSH = 2'd0, OP_POP = 2'd1, OP_FIND = 2'd2, OP_READ = 2'd3} op_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_FULL = 2'd1, ST_EMPTY = 2'd2,
                              ST_NOTFOUND = 2'd3} status_t;
    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_READ, S_SEND} state_t;
    typedef struct packed {
        op_t         op;
        logic [31:0] key;
        logic [31:0] data;
        logic [7:0]  position;
    } cmd_t;
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] data;
        status_t     status;
        logic [7:0]  count;
    } rsp_t;
endpackage
`default_nettype wire

/* hdl/fwks_front.sv */
// Front end: accept input transactions and hold them in a two-entry command queue.
// Depends on fwks_pkg.
`default_nettype none
module fwks_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire fwks_pkg::cmd_t in_cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output fwks_pkg::cmd_t     cmd
);
    import fwks_pkg::*;

    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] n_reg;
    logic       push, pop;

    assign in_ready  = (n_reg != 2'd2);
    assign cmd_valid = (n_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= in_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            n_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            n_reg <= n_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

/* hdl/fwks_back.sv */
// Back end: ring buffer in a memory, pointer control and a key scan over stored entries.
// Depends on fwks_pkg.
`default_nettype none
module fwks_back
#(
    parameter int QUEUE_DEPTH = 128
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire fwks_pkg::cmd_t cmd,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output fwks_pkg::rsp_t      rsp
);
    import fwks_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [63:0]   mem [QUEUE_DEPTH];
    logic [63:0]   rd_reg;
    state_t        state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    cmd_t          c_reg, c_next;
    rsp_t          rsp_reg, rsp_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
        logic [CW:0] s;
        s = {{(CW+1-AW){1'b0}}, h} + {1'b0, off};
        if (s >= (CW+1)'(QUEUE_DEPTH))
        begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp_valid = (state_reg == S_SEND);
    assign rsp       = rsp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {c_next.key, c_next.data};
        end
        rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        c_next     = c_reg;
        rsp_next   = rsp_reg;
        wr_en      = 1'b0;
        wr_addr    = slot(head_reg, cnt_reg);
        rd_addr    = slot(head_reg, idx_reg);
        case (state_reg)
            S_IDLE:
            begin
                c_next = cmd;
                if (cmd_valid)
                begin
                    rsp_next = '0;
                    idx_next = '0;
                    case (cmd.op)
                        OP_PUSH:
                        begin
                            if (cnt_reg == CW'(QUEUE_DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + 1'b1;
                            end
                            rsp_next.count = 8'(cnt_next);
                            state_next = S_SEND;
                        end
                        OP_POP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_next.status = ST_EMPTY;
                                state_next = S_SEND;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                state_next = S_READ;
                            end
                            rsp_next.count = 8'(cnt_reg);
                        end
                        OP_FIND:
                        begin
                            rsp_next.count  = 8'(cnt_reg);
                            rsp_next.status = ST_NOTFOUND;
                            if (cnt_reg == '0)
                            begin
                                state_next = S_SEND;
                            end
                            else
                            begin
                                rd_addr    = head_reg;
                                idx_next   = CW'(1);
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            rsp_next.count = 8'(cnt_reg);
                            if (cmd.position != 8'd0 &&
                                {{CW{1'b0}}, cmd.position} <= {8'd0, cnt_reg})
                            begin
                                rd_addr    = slot(head_reg, CW'(cmd.position - 8'd1));
                                state_next = S_READ;
                            end
                            else
                            begin
                                rsp_next.status = ST_NOTFOUND;
                                state_next = S_SEND;
                            end
                        end
                    endcase
                end
            end
            S_READ:
            begin
                rsp_next.key  = rd_reg[63:32];
                rsp_next.data = rd_reg[31:0];
                if (c_reg.op == OP_POP)
                begin
                    head_next      = slot(head_reg, CW'(1));
                    cnt_next       = cnt_reg - 1'b1;
                    rsp_next.count = 8'(cnt_next);
                end
                state_next = S_SEND;
            end
            S_SCAN:
            begin
                if (rd_reg[63:32] == c_reg.key)
                begin
                    rsp_next.key    = rd_reg[63:32];
                    rsp_next.data   = rd_reg[31:0];
                    rsp_next.status = ST_OK;
                    state_next      = S_SEND;
                end
                else if (idx_reg == cnt_reg)
                begin
                    state_next = S_SEND;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_SEND:
            begin
                if (rsp_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        rsp_reg <= rsp_next;
        idx_reg <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
        end
    end
endmodule
`default_nettype wire

/* hdl/fifo_with_key_search.sv */
// Top level of the keyed FIFO: command queue front end and ring-buffer back end.
// Depends on fwks_pkg, fwks_front, fwks_back.
`default_nettype none
// Bounded FIFO of key/data entries with push, pop, find-by-key and read-by-position.
// One result per transaction. A find scans the stored entries from the head through
// one memory read port, one entry per cycle, until a key matches or all are checked.
// A two-entry command queue takes the next transaction while the back end works or
// its result waits.
module fifo_with_key_search
#(
    parameter int QUEUE_DEPTH = 128
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,  // entry_key, entry_data, position
    input  wire logic [1:0]  s_tuser,  // operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [71:0]      m_tdata,  // out_key, out_data, count
    output logic [1:0]       m_tuser   // status
);
    import fwks_pkg::*;

    cmd_t in_cmd, cmd;
    rsp_t rsp;
    logic cmd_valid, cmd_ready;

    assign in_cmd.op       = op_t'(s_tuser);
    assign in_cmd.key      = s_tdata[31:0];
    assign in_cmd.data     = s_tdata[63:32];
    assign in_cmd.position = s_tdata[71:64];

    fwks_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd(in_cmd),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
    );

    fwks_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back
    (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
        .rsp_valid(m_tvalid), .rsp_ready(m_tready), .rsp(rsp)
    );

    assign m_tdata = {rsp.count, rsp.data, rsp.key};
    assign m_tuser = rsp.status;
endmodule
`default_nettype wire

/* hdl/fwks_checker.sv */
// Port-level checker for the keyed FIFO, bound to the top level.
// Depends on fifo_with_key_search.
`default_nettype none
module fwks_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [71:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");
    // failed operations carry zero key and data
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != 2'd0 |-> m_tdata[63:0] == 64'd0)
        else $error("failed result with nonzero payload");
    // empty pop reports zero count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == 2'd2 |-> m_tdata[71:64] == 8'd0)
        else $error("empty status with nonzero count");
endmodule

bind fifo_with_key_search fwks_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
